FILE: rtl/bresenham_line_rasterizer_assert.svh
// Assertion macros used by the top level of the line rasterizer.
`ifndef BRESENHAM_LINE_RASTERIZER_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define BLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/blr_pkg.sv
// Shared types and constants of the line rasterizer.
`default_nettype none

package blr_pkg;

  // Fixed field widths.
  localparam int ADDR_W  = 32;
  localparam int COLOR_W = 32;
  localparam int PITCH_W = 16;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Command queue geometry.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH  = 1'b1;

  // Reset value of the row pitch.
  localparam logic [PITCH_W-1:0] ROW_PITCH_RST = 16'd256;

  // Step direction codes, two's complement of -1, 0 and +1.
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  // Status of the pixel walker as seen by the top level.
  typedef struct packed {
    logic busy;
    logic fire;
    logic last;
  } blr_back_stat_t;

endpackage

`default_nettype wire

FILE: rtl/blr_front.sv
// Front end: classifies a line command into walker setup values.
`default_nettype none

module blr_front
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic [COORD_BITS-1:0]   start_x,
  input  wire logic [COORD_BITS-1:0]   start_y,
  input  wire logic [COORD_BITS-1:0]   end_x,
  input  wire logic [COORD_BITS-1:0]   end_y,
  input  wire logic [ADDR_W-1:0]       frame_base,
  input  wire logic [PITCH_W-1:0]      row_pitch,
  output logic [COORD_BITS:0]          twice_dx,
  output logic [COORD_BITS:0]          twice_dy,
  output logic [1:0]                   step_x,
  output logic [1:0]                   step_y,
  output logic                         x_major,
  output logic signed [COORD_BITS+2:0] error_init,
  output logic [ADDR_W-1:0]            row_address
);

  localparam int PROD_W = COORD_BITS + PITCH_W;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      abs_dx;
  logic [COORD_BITS-1:0]      abs_dy;
  logic [PROD_W-1:0]          row_offset;

  // Signed deltas and their magnitudes.
  always_comb begin
    dx = signed'({1'b0, end_x}) - signed'({1'b0, start_x});
    dy = signed'({1'b0, end_y}) - signed'({1'b0, start_y});
    abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    twice_dx = {abs_dx, 1'b0};
    twice_dy = {abs_dy, 1'b0};
  end

  // Step directions per axis.
  always_comb begin
    if (dx == '0) begin
      step_x = STEP_ZERO;
    end else if (dx[COORD_BITS]) begin
      step_x = STEP_NEG;
    end else begin
      step_x = STEP_POS;
    end
    if (dy == '0) begin
      step_y = STEP_ZERO;
    end else if (dy[COORD_BITS]) begin
      step_y = STEP_NEG;
    end else begin
      step_y = STEP_POS;
    end
  end

  // Major axis choice and starting error term; ties go to y.
  always_comb begin
    x_major = twice_dx > twice_dy;
    if (x_major) begin
      error_init = signed'({2'b00, twice_dy}) - signed'({3'b000, abs_dx});
    end else begin
      error_init = signed'({2'b00, twice_dx}) - signed'({3'b000, abs_dy});
    end
  end

  // Address of the first row of the line.
  always_comb begin
    row_offset  = PROD_W'(start_y) * PROD_W'(row_pitch);
    row_address = frame_base + ADDR_W'(row_offset);
  end

endmodule

`default_nettype wire

FILE: rtl/blr_queue.sv
// Two-entry command queue between the front end and the pixel walker.
`default_nettype none

module blr_queue
  import blr_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output logic [DATA_W-1:0]      pop_data
);

  logic [DATA_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/blr_back.sv
// Pixel walker: steps one line point per cycle, while the output is not stalled, into an output register.
`default_nettype none

module blr_back
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_valid,
  output logic                              cmd_ready,
  input  wire logic [COORD_BITS-1:0]        cmd_start_x,
  input  wire logic [COORD_BITS-1:0]        cmd_start_y,
  input  wire logic [COORD_BITS-1:0]        cmd_end_x,
  input  wire logic [COORD_BITS-1:0]        cmd_end_y,
  input  wire logic [COORD_BITS:0]          cmd_twice_dx,
  input  wire logic [COORD_BITS:0]          cmd_twice_dy,
  input  wire logic [1:0]                   cmd_step_x,
  input  wire logic [1:0]                   cmd_step_y,
  input  wire logic                         cmd_x_major,
  input  wire logic signed [COORD_BITS+2:0] cmd_error_init,
  input  wire logic [ADDR_W-1:0]            cmd_row_address,
  input  wire logic [COLOR_W-1:0]           cmd_color,
  input  wire logic [PITCH_W-1:0]           row_pitch,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [COORD_BITS-1:0]             out_pixel_x,
  output logic [COORD_BITS-1:0]             out_pixel_y,
  output logic [ADDR_W-1:0]                 out_pixel_address,
  output logic [COLOR_W-1:0]                out_pixel_value,
  output logic                              out_last_pixel,
  output blr_back_stat_t                    stat
);

  localparam int ERR_W = COORD_BITS + 3;

  // Walker state.
  logic                    active_r, active_nxt;
  logic [COORD_BITS-1:0]   walk_x_r, walk_x_nxt;
  logic [COORD_BITS-1:0]   walk_y_r, walk_y_nxt;
  logic [COORD_BITS-1:0]   target_x_r;
  logic [COORD_BITS-1:0]   target_y_r;
  logic [COORD_BITS:0]     twice_dx_r;
  logic [COORD_BITS:0]     twice_dy_r;
  logic [1:0]              step_x_r;
  logic [1:0]              step_y_r;
  logic                    x_major_r;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [ADDR_W-1:0]       row_r, row_nxt;
  logic [COLOR_W-1:0]      color_r;

  // Output register.
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic [ADDR_W-1:0]     out_addr_r;
  logic [COLOR_W-1:0]    out_value_r;
  logic                  out_last_r;

  logic                    load;
  logic                    fire;
  logic                    last;
  logic                    err_ge;
  logic                    move_x;
  logic                    move_y;
  logic signed [ERR_W-1:0] err_mid;
  logic [ADDR_W-1:0]       pixel_addr;

  assign cmd_ready = !active_r;
  assign load      = cmd_valid && !active_r;
  assign fire      = active_r && (!out_valid_r || out_ready);

  // Decide this point and the next step.
  always_comb begin
    last    = x_major_r ? (walk_x_r == target_x_r) : (walk_y_r == target_y_r);
    err_ge  = !err_r[ERR_W-1];
    move_x  = x_major_r || err_ge;
    move_y  = !x_major_r || err_ge;
    if (err_ge) begin
      err_mid = x_major_r ? err_r - signed'({2'b00, twice_dx_r})
                          : err_r - signed'({2'b00, twice_dy_r});
    end else begin
      err_mid = err_r;
    end
    pixel_addr = row_r + ADDR_W'({walk_x_r, 2'b00});
  end

  // Next walker state.
  always_comb begin
    active_nxt = active_r;
    walk_x_nxt = walk_x_r;
    walk_y_nxt = walk_y_r;
    err_nxt    = err_r;
    row_nxt    = row_r;
    if (load) begin
      active_nxt = 1'b1;
      walk_x_nxt = cmd_start_x;
      walk_y_nxt = cmd_start_y;
      err_nxt    = cmd_error_init;
      row_nxt    = cmd_row_address;
    end else if (fire) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = x_major_r ? err_mid + signed'({2'b00, twice_dy_r})
                            : err_mid + signed'({2'b00, twice_dx_r});
        if (move_x) begin
          walk_x_nxt = walk_x_r + {{(COORD_BITS-2){step_x_r[1]}}, step_x_r};
        end
        if (move_y) begin
          walk_y_nxt = walk_y_r + {{(COORD_BITS-2){step_y_r[1]}}, step_y_r};
          case (step_y_r)
            STEP_POS: row_nxt = row_r + ADDR_W'(row_pitch);
            STEP_NEG: row_nxt = row_r - ADDR_W'(row_pitch);
            default:  row_nxt = row_r;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walker payload registers.
  always_ff @(posedge clk) begin
    walk_x_r <= walk_x_nxt;
    walk_y_r <= walk_y_nxt;
    err_r    <= err_nxt;
    row_r    <= row_nxt;
    if (load) begin
      target_x_r <= cmd_end_x;
      target_y_r <= cmd_end_y;
      twice_dx_r <= cmd_twice_dx;
      twice_dy_r <= cmd_twice_dy;
      step_x_r   <= cmd_step_x;
      step_y_r   <= cmd_step_y;
      x_major_r  <= cmd_x_major;
      color_r    <= cmd_color;
    end
  end

  // Output word capture.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_x_r     <= walk_x_r;
      out_y_r     <= walk_y_r;
      out_addr_r  <= pixel_addr;
      out_value_r <= color_r;
      out_last_r  <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = out_x_r;
  assign out_pixel_y       = out_y_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_value   = out_value_r;
  assign out_last_pixel    = out_last_r;

  assign stat.busy = active_r;
  assign stat.fire = fire;
  assign stat.last = last;

endmodule

`default_nettype wire

FILE: rtl/bresenham_line_rasterizer.sv
// Top level of the line rasterizer: config registers, front end, queue, walker.
// A pixel word of a line is registered in the queue, then in the walker state, then in the output register.
// Throughput: one pixel word per cycle while out_ready does not stall the output, for a line of
// up to 64 pixels, with a load of the next command from the queue between lines.
// The walker's single error-term update per cycle sets that rate; the queue holds two commands.
// Reset: frame_base clears to 0, row_pitch goes to 256, queue and walker come up empty.
`default_nettype none

`include "bresenham_line_rasterizer_assert.svh"

module bresenham_line_rasterizer
  import blr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  // Command channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] in_start_x,
  input  wire logic [COORD_BITS-1:0] in_start_y,
  input  wire logic [COORD_BITS-1:0] in_end_x,
  input  wire logic [COORD_BITS-1:0] in_end_y,
  input  wire logic [COLOR_W-1:0]    in_line_color,
  // Pixel channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [COORD_BITS-1:0]      out_pixel_x,
  output logic [COORD_BITS-1:0]      out_pixel_y,
  output logic [ADDR_W-1:0]          out_pixel_address,
  output logic [COLOR_W-1:0]         out_pixel_value,
  output logic                       out_last_pixel
);

  localparam int ERR_W = COORD_BITS + 3;
  localparam int CMD_W = 4 * COORD_BITS + 2 * (COORD_BITS + 1) + 4 + 1 + ERR_W
                         + ADDR_W + COLOR_W;

  logic [ADDR_W-1:0]  frame_base_r;
  logic [PITCH_W-1:0] row_pitch_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      row_pitch_r  <= ROW_PITCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_BASE: frame_base_r <= cfg_wdata[ADDR_W-1:0];
        CFG_ROW_PITCH:  row_pitch_r  <= cfg_wdata[PITCH_W-1:0];
        default:        ;
      endcase
    end
  end

  // Front end.
  logic [COORD_BITS:0]     f_twice_dx, f_twice_dy;
  logic [1:0]              f_step_x, f_step_y;
  logic                    f_x_major;
  logic signed [ERR_W-1:0] f_error_init;
  logic [ADDR_W-1:0]       f_row_address;

  blr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .frame_base  (frame_base_r),
    .row_pitch   (row_pitch_r),
    .twice_dx    (f_twice_dx),
    .twice_dy    (f_twice_dy),
    .step_x      (f_step_x),
    .step_y      (f_step_y),
    .x_major     (f_x_major),
    .error_init  (f_error_init),
    .row_address (f_row_address)
  );

  // Command queue.
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [CMD_W-1:0] q_push_data;
  logic [CMD_W-1:0] q_pop_data;

  assign in_ready    = !q_full;
  assign q_push_data = {in_start_x, in_start_y, in_end_x, in_end_y, f_twice_dx, f_twice_dy,
                        f_step_x, f_step_y, f_x_major, f_error_init, f_row_address,
                        in_line_color};

  blr_queue #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  // Unpack the queued command.
  logic [COORD_BITS-1:0]   c_start_x, c_start_y, c_end_x, c_end_y;
  logic [COORD_BITS:0]     c_twice_dx, c_twice_dy;
  logic [1:0]              c_step_x, c_step_y;
  logic                    c_x_major;
  logic signed [ERR_W-1:0] c_error_init;
  logic [ADDR_W-1:0]       c_row_address;
  logic [COLOR_W-1:0]      c_color;

  assign {c_start_x, c_start_y, c_end_x, c_end_y, c_twice_dx, c_twice_dy, c_step_x,
          c_step_y, c_x_major, c_error_init, c_row_address, c_color} = q_pop_data;

  // Pixel walker.
  blr_back_stat_t back_stat;

  blr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_ready         (q_pop),
    .cmd_start_x       (c_start_x),
    .cmd_start_y       (c_start_y),
    .cmd_end_x         (c_end_x),
    .cmd_end_y         (c_end_y),
    .cmd_twice_dx      (c_twice_dx),
    .cmd_twice_dy      (c_twice_dy),
    .cmd_step_x        (c_step_x),
    .cmd_step_y        (c_step_y),
    .cmd_x_major       (c_x_major),
    .cmd_error_init    (c_error_init),
    .cmd_row_address   (c_row_address),
    .cmd_color         (c_color),
    .row_pitch         (row_pitch_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_last_pixel    (out_last_pixel),
    .stat              (back_stat)
  );

  // An accepted command is waiting in the queue on the next cycle.
  `BLR_ASSERT_NEXT(a_push_lands, in_valid && in_ready, q_valid, "accepted command lost")
  // The walker goes idle right after emitting the last point of a line.
  `BLR_ASSERT_NEXT(a_last_ends, back_stat.fire && back_stat.last, !back_stat.busy, "walker overran line end")
  // With nothing queued or in flight, no pixel word can appear.
  `BLR_ASSERT_NEXT(a_no_phantom, !back_stat.busy && !q_valid && (!out_valid || out_ready), !out_valid, "pixel without command")

endmodule

`default_nettype wire
